/* design/cpu8_pkg.sv */
// Package with the item types, operation codes and status flag layout of the 8-bit execute unit.
`default_nettype none

package cpu8_pkg;

    // Operation codes carried in the cmd field
    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
        OP_EOR = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
        OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
        OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
        OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
        OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
        OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
        OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_CLC = 6'd31,
        OP_SEC = 6'd32, OP_CLI = 6'd33, OP_SEI = 6'd34, OP_CLV = 6'd35,
        OP_CLD = 6'd36, OP_SED = 6'd37, OP_NOP = 6'd38, OP_BPL = 6'd39,
        OP_BMI = 6'd40, OP_BVC = 6'd41, OP_BVS = 6'd42, OP_BCC = 6'd43,
        OP_BCS = 6'd44, OP_BNE = 6'd45, OP_BEQ = 6'd46
    } cmd_e_t;

    // Status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    // Status after reset: only the unused bit set
    localparam logic [7:0] STATUS_RESET = 8'h20;

    typedef struct packed {
        logic [5:0] cmd;
        logic [7:0] operand;
        logic       on_accumulator;
    } req_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] sp_out;
        logic [7:0] status_out;
        logic [7:0] mem_value;
        logic       write_back;
        logic       branch_taken;
    } rsp_t;

endpackage

`default_nettype wire

/* design/cpu8_register_alu_execute_unit.sv */
// Register and ALU execute unit for an 8-bit 6502-style processor.
//
// Usage:
//   The req channel (req_valid/req_ready/req) carries one instruction per
//   transfer: an operation code, the operand byte already fetched by the
//   addressing logic, and the accumulator select for shifts and rotates.
//   The rsp channel (rsp_valid/rsp_ready/rsp) returns one result per
//   instruction: A, X, Y, SP and status after the instruction, the
//   write-back byte with its strobe, and the branch decision.
//   An instruction passes through the input register, then the result
//   register. Throughput is one instruction per cycle unless the receiver
//   stalls, bounded by the single 8-bit add or logic step between the input
//   register and the register file, which feeds the next instruction directly.
//   Reset clears A, X, Y and SP, sets status to 0x20 and empties both
//   stages. When the receiver stalls, the result register holds, the input
//   register fills behind it, and req_ready drops only once both are full.
`default_nettype none

module cpu8_register_alu_execute_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire cpu8_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output cpu8_pkg::rsp_t       rsp
);

    // Pipeline control and payload
    logic           in_valid_reg;
    cpu8_pkg::req_t in_item_reg;
    logic           out_valid_reg;
    cpu8_pkg::rsp_t out_item_reg;
    logic           advance;

    // Architectural registers
    logic [7:0] acc_reg,    acc_next;
    logic [7:0] x_reg,      x_next;
    logic [7:0] y_reg,      y_next;
    logic [7:0] sp_reg,     sp_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] mem_next;
    logic       wb_next;
    logic       br_next;

    // Datapath intermediates
    cpu8_pkg::cmd_e_t op;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_src;
    logic [8:0] diff;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_cout;
    logic [7:0] zn_val;
    logic       zn_upd;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // Decode and execute the instruction held in the input register
    always_comb
    begin
        op          = cpu8_pkg::cmd_e_t'(in_item_reg.cmd);
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        mem_next    = 8'h00;
        wb_next     = 1'b0;
        br_next     = 1'b0;
        zn_val      = 8'h00;
        zn_upd      = 1'b0;

        // Adder, shared by ADC and SBC (inverted operand)
        addend = (op == cpu8_pkg::OP_SBC) ? ~in_item_reg.operand : in_item_reg.operand;
        sum    = {1'b0, acc_reg} + {1'b0, addend} + {8'h00, status_reg[cpu8_pkg::FLAG_C]};

        // Comparator source
        case (op)
            cpu8_pkg::OP_CPX: cmp_src = x_reg;
            cpu8_pkg::OP_CPY: cmp_src = y_reg;
            default:          cmp_src = acc_reg;
        endcase
        diff = {1'b0, cmp_src} - {1'b0, in_item_reg.operand};

        // Shifter
        sh_src = in_item_reg.on_accumulator ? acc_reg : in_item_reg.operand;
        case (op)
            cpu8_pkg::OP_ASL:
            begin
                sh_cout = sh_src[7];
                sh_res  = {sh_src[6:0], 1'b0};
            end
            cpu8_pkg::OP_LSR:
            begin
                sh_cout = sh_src[0];
                sh_res  = {1'b0, sh_src[7:1]};
            end
            cpu8_pkg::OP_ROL:
            begin
                sh_cout = sh_src[7];
                sh_res  = {sh_src[6:0], status_reg[cpu8_pkg::FLAG_C]};
            end
            default:
            begin
                sh_cout = sh_src[0];
                sh_res  = {status_reg[cpu8_pkg::FLAG_C], sh_src[7:1]};
            end
        endcase

        unique case (op) inside
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                acc_next = sum[7:0];
                status_next[cpu8_pkg::FLAG_C] = sum[8];
                status_next[cpu8_pkg::FLAG_V] =
                    ~(acc_reg[7] ^ addend[7]) & (acc_reg[7] ^ sum[7]);
                zn_val = sum[7:0];
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_AND:
            begin
                acc_next = acc_reg & in_item_reg.operand;
                zn_val   = acc_next;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_ORA:
            begin
                acc_next = acc_reg | in_item_reg.operand;
                zn_val   = acc_next;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_EOR:
            begin
                acc_next = acc_reg ^ in_item_reg.operand;
                zn_val   = acc_next;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY:
            begin
                status_next[cpu8_pkg::FLAG_C] = ~diff[8];
                status_next[cpu8_pkg::FLAG_Z] = (cmp_src == in_item_reg.operand);
                status_next[cpu8_pkg::FLAG_N] = diff[7];
            end
            cpu8_pkg::OP_BIT:
            begin
                status_next[cpu8_pkg::FLAG_Z] = ((acc_reg & in_item_reg.operand) == 8'h00);
                status_next[cpu8_pkg::FLAG_N] = in_item_reg.operand[7];
                status_next[cpu8_pkg::FLAG_V] = in_item_reg.operand[6];
            end
            cpu8_pkg::OP_ASL, cpu8_pkg::OP_LSR, cpu8_pkg::OP_ROL, cpu8_pkg::OP_ROR:
            begin
                status_next[cpu8_pkg::FLAG_C] = sh_cout;
                zn_val = sh_res;
                zn_upd = 1'b1;
                if (in_item_reg.on_accumulator)
                begin
                    acc_next = sh_res;
                end
                else
                begin
                    mem_next = sh_res;
                    wb_next  = 1'b1;
                end
            end
            cpu8_pkg::OP_INC:
            begin
                mem_next = in_item_reg.operand + 8'd1;
                wb_next  = 1'b1;
                zn_val   = mem_next;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_DEC:
            begin
                mem_next = in_item_reg.operand - 8'd1;
                wb_next  = 1'b1;
                zn_val   = mem_next;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_INX:
            begin
                x_next = x_reg + 8'd1;
                zn_val = x_next;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_INY:
            begin
                y_next = y_reg + 8'd1;
                zn_val = y_next;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_DEX:
            begin
                x_next = x_reg - 8'd1;
                zn_val = x_next;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_DEY:
            begin
                y_next = y_reg - 8'd1;
                zn_val = y_next;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_LDA:
            begin
                acc_next = in_item_reg.operand;
                zn_val   = in_item_reg.operand;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_LDX:
            begin
                x_next = in_item_reg.operand;
                zn_val = in_item_reg.operand;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_LDY:
            begin
                y_next = in_item_reg.operand;
                zn_val = in_item_reg.operand;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_STA:
            begin
                mem_next = acc_reg;
                wb_next  = 1'b1;
            end
            cpu8_pkg::OP_STX:
            begin
                mem_next = x_reg;
                wb_next  = 1'b1;
            end
            cpu8_pkg::OP_STY:
            begin
                mem_next = y_reg;
                wb_next  = 1'b1;
            end
            cpu8_pkg::OP_TAX:
            begin
                x_next = acc_reg;
                zn_val = acc_reg;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_TAY:
            begin
                y_next = acc_reg;
                zn_val = acc_reg;
                zn_upd = 1'b1;
            end
            cpu8_pkg::OP_TXA:
            begin
                acc_next = x_reg;
                zn_val   = x_reg;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_TYA:
            begin
                acc_next = y_reg;
                zn_val   = y_reg;
                zn_upd   = 1'b1;
            end
            cpu8_pkg::OP_TSX:
            begin
                x_next = sp_reg;
                zn_val = sp_reg;
                zn_upd = 1'b1;
            end
            // TXS leaves the flags alone
            cpu8_pkg::OP_TXS: sp_next = x_reg;
            cpu8_pkg::OP_CLC: status_next[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::OP_SEC: status_next[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::OP_CLI: status_next[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::OP_SEI: status_next[cpu8_pkg::FLAG_I] = 1'b1;
            cpu8_pkg::OP_CLV: status_next[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::OP_CLD: status_next[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::OP_SED: status_next[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::OP_BPL: br_next = ~status_reg[cpu8_pkg::FLAG_N];
            cpu8_pkg::OP_BMI: br_next =  status_reg[cpu8_pkg::FLAG_N];
            cpu8_pkg::OP_BVC: br_next = ~status_reg[cpu8_pkg::FLAG_V];
            cpu8_pkg::OP_BVS: br_next =  status_reg[cpu8_pkg::FLAG_V];
            cpu8_pkg::OP_BCC: br_next = ~status_reg[cpu8_pkg::FLAG_C];
            cpu8_pkg::OP_BCS: br_next =  status_reg[cpu8_pkg::FLAG_C];
            cpu8_pkg::OP_BNE: br_next = ~status_reg[cpu8_pkg::FLAG_Z];
            cpu8_pkg::OP_BEQ: br_next =  status_reg[cpu8_pkg::FLAG_Z];
            // NOP and unassigned codes change nothing
            default:
            begin
            end
        endcase

        // Apply zero and negative from the selected result
        if (zn_upd)
        begin
            status_next[cpu8_pkg::FLAG_Z] = (zn_val == 8'h00);
            status_next[cpu8_pkg::FLAG_N] = zn_val[7];
        end
    end

    // Input register: take a transfer when empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_item_reg <= req;
        end
    end

    // Register file: commit when the instruction moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= 8'h00;
            x_reg      <= 8'h00;
            y_reg      <= 8'h00;
            sp_reg     <= 8'h00;
            status_reg <= cpu8_pkg::STATUS_RESET;
        end
        else if (advance)
        begin
            acc_reg    <= acc_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.acc_out      <= acc_next;
            out_item_reg.x_out        <= x_next;
            out_item_reg.y_out        <= y_next;
            out_item_reg.sp_out       <= sp_next;
            out_item_reg.status_out   <= status_next;
            out_item_reg.mem_value    <= mem_next;
            out_item_reg.write_back   <= wb_next;
            out_item_reg.branch_taken <= br_next;
        end
    end

endmodule

`default_nettype wire

/* bench/cpu8_register_alu_execute_unit_tb.sv */
// Self-checking testbench for the 8-bit register and ALU execute unit.
`default_nettype none

module cpu8_register_alu_execute_unit_tb;

    localparam int unsigned RANDOM_INSTRS = 1900;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam logic [5:0] CMD_UNUSED_TOP = 6'd63;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    cpu8_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    cpu8_pkg::rsp_t rsp;

    // Instructions waiting to be sent and results waiting to come back
    cpu8_pkg::req_t pending_instrs[$];
    cpu8_pkg::rsp_t expected_results[$];

    // Architectural state as the predictor sees it
    logic [7:0] arch_a = 8'h00;
    logic [7:0] arch_x = 8'h00;
    logic [7:0] arch_y = 8'h00;
    logic [7:0] arch_sp = 8'h00;
    logic [7:0] arch_status = cpu8_pkg::STATUS_RESET;

    // Handshake bookkeeping shared between the edges
    bit req_taken = 1'b0;
    bit rsp_taken = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;

    cpu8_register_alu_execute_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Update Z and N from a result byte
    function automatic void set_zn(input logic [7:0] value);
        arch_status[cpu8_pkg::FLAG_Z] = (value == 8'h00);
        arch_status[cpu8_pkg::FLAG_N] = value[7];
    endfunction

    // Compare flags: C on no borrow, Z on equal, N from the difference
    function automatic void compare_flags(input logic [7:0] lhs, input logic [7:0] rhs);
        logic [7:0] diff;
        diff = lhs - rhs;
        arch_status[cpu8_pkg::FLAG_C] = (lhs >= rhs);
        arch_status[cpu8_pkg::FLAG_Z] = (lhs == rhs);
        arch_status[cpu8_pkg::FLAG_N] = diff[7];
    endfunction

    // Apply one instruction to the predicted state and return its result
    function automatic cpu8_pkg::rsp_t execute_instr(input cpu8_pkg::req_t instr);
        logic [7:0] m;
        logic [7:0] src;
        logic [7:0] res;
        logic [7:0] addend;
        logic [7:0] mem;
        logic [8:0] sum;
        logic cin;
        logic cout;
        logic wb;
        logic br;
        cpu8_pkg::rsp_t result;
        m = instr.operand;
        mem = 8'h00;
        wb = 1'b0;
        br = 1'b0;
        cin = arch_status[cpu8_pkg::FLAG_C];
        case (instr.cmd)
            cpu8_pkg::OP_ASL, cpu8_pkg::OP_LSR, cpu8_pkg::OP_ROL, cpu8_pkg::OP_ROR:
            begin
                src = instr.on_accumulator ? arch_a : m;
                case (instr.cmd)
                    cpu8_pkg::OP_ASL: {cout, res} = {src, 1'b0};
                    cpu8_pkg::OP_LSR: {res, cout} = {1'b0, src};
                    cpu8_pkg::OP_ROL: {cout, res} = {src, cin};
                    default: {res, cout} = {cin, src};
                endcase
                arch_status[cpu8_pkg::FLAG_C] = cout;
                set_zn(res);
                if (instr.on_accumulator)
                begin
                    arch_a = res;
                end
                else
                begin
                    mem = res;
                    wb = 1'b1;
                end
            end
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                // Subtract is add of the inverted operand, binary only
                addend = (instr.cmd == cpu8_pkg::OP_SBC) ? ~m : m;
                sum = {1'b0, arch_a} + {1'b0, addend} + {8'h00, cin};
                res = sum[7:0];
                arch_status[cpu8_pkg::FLAG_C] = sum[8];
                arch_status[cpu8_pkg::FLAG_V] =
                    ~(arch_a[7] ^ addend[7]) & (arch_a[7] ^ res[7]);
                arch_a = res;
                set_zn(res);
            end
            cpu8_pkg::OP_AND: begin arch_a = arch_a & m; set_zn(arch_a); end
            cpu8_pkg::OP_ORA: begin arch_a = arch_a | m; set_zn(arch_a); end
            cpu8_pkg::OP_EOR: begin arch_a = arch_a ^ m; set_zn(arch_a); end
            cpu8_pkg::OP_CMP: compare_flags(arch_a, m);
            cpu8_pkg::OP_CPX: compare_flags(arch_x, m);
            cpu8_pkg::OP_CPY: compare_flags(arch_y, m);
            cpu8_pkg::OP_BIT:
            begin
                arch_status[cpu8_pkg::FLAG_Z] = ((arch_a & m) == 8'h00);
                arch_status[cpu8_pkg::FLAG_N] = m[7];
                arch_status[cpu8_pkg::FLAG_V] = m[6];
            end
            cpu8_pkg::OP_INC: begin mem = m + 8'd1; set_zn(mem); wb = 1'b1; end
            cpu8_pkg::OP_DEC: begin mem = m - 8'd1; set_zn(mem); wb = 1'b1; end
            cpu8_pkg::OP_INX: begin arch_x = arch_x + 8'd1; set_zn(arch_x); end
            cpu8_pkg::OP_INY: begin arch_y = arch_y + 8'd1; set_zn(arch_y); end
            cpu8_pkg::OP_DEX: begin arch_x = arch_x - 8'd1; set_zn(arch_x); end
            cpu8_pkg::OP_DEY: begin arch_y = arch_y - 8'd1; set_zn(arch_y); end
            cpu8_pkg::OP_LDA: begin arch_a = m; set_zn(m); end
            cpu8_pkg::OP_LDX: begin arch_x = m; set_zn(m); end
            cpu8_pkg::OP_LDY: begin arch_y = m; set_zn(m); end
            cpu8_pkg::OP_STA: begin mem = arch_a; wb = 1'b1; end
            cpu8_pkg::OP_STX: begin mem = arch_x; wb = 1'b1; end
            cpu8_pkg::OP_STY: begin mem = arch_y; wb = 1'b1; end
            cpu8_pkg::OP_TAX: begin arch_x = arch_a; set_zn(arch_x); end
            cpu8_pkg::OP_TAY: begin arch_y = arch_a; set_zn(arch_y); end
            cpu8_pkg::OP_TXA: begin arch_a = arch_x; set_zn(arch_a); end
            cpu8_pkg::OP_TYA: begin arch_a = arch_y; set_zn(arch_a); end
            cpu8_pkg::OP_TSX: begin arch_x = arch_sp; set_zn(arch_x); end
            // Stack pointer load leaves the flags alone
            cpu8_pkg::OP_TXS: arch_sp = arch_x;
            cpu8_pkg::OP_CLC: arch_status[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::OP_SEC: arch_status[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::OP_CLI: arch_status[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::OP_SEI: arch_status[cpu8_pkg::FLAG_I] = 1'b1;
            cpu8_pkg::OP_CLV: arch_status[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::OP_CLD: arch_status[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::OP_SED: arch_status[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::OP_BPL: br = ~arch_status[cpu8_pkg::FLAG_N];
            cpu8_pkg::OP_BMI: br = arch_status[cpu8_pkg::FLAG_N];
            cpu8_pkg::OP_BVC: br = ~arch_status[cpu8_pkg::FLAG_V];
            cpu8_pkg::OP_BVS: br = arch_status[cpu8_pkg::FLAG_V];
            cpu8_pkg::OP_BCC: br = ~arch_status[cpu8_pkg::FLAG_C];
            cpu8_pkg::OP_BCS: br = arch_status[cpu8_pkg::FLAG_C];
            cpu8_pkg::OP_BNE: br = ~arch_status[cpu8_pkg::FLAG_Z];
            cpu8_pkg::OP_BEQ: br = arch_status[cpu8_pkg::FLAG_Z];
            // NOP and the unassigned codes change nothing
            default: ;
        endcase
        result.acc_out = arch_a;
        result.x_out = arch_x;
        result.y_out = arch_y;
        result.sp_out = arch_sp;
        result.status_out = arch_status;
        result.mem_value = mem;
        result.write_back = wb;
        result.branch_taken = br;
        return result;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic queue_instr(input logic [5:0] cmd, input logic [7:0] operand,
                               input logic on_acc);
        cpu8_pkg::req_t instr;
        instr.cmd = cmd;
        instr.operand = operand;
        instr.on_accumulator = on_acc;
        pending_instrs.push_back(instr);
    endtask

    // Drive the request channel from the pending queue
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_instrs.size() > 0)
            begin
                req <= pending_instrs.pop_front();
                req_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 19);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel for a random count after each transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_taken = 1'b0;
                if ($urandom_range(0, 49) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 19);
            end
            if (recv_stall > 0)
            begin
                rsp_ready <= 1'b0;
                recv_stall--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Check results, predict accepted instructions, and watch for a hang
    always @(posedge clk)
    begin
        cpu8_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_taken = 1'b1;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no instruction outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("acc_out", want.acc_out, rsp.acc_out);
                    check_field("x_out", want.x_out, rsp.x_out);
                    check_field("y_out", want.y_out, rsp.y_out);
                    check_field("sp_out", want.sp_out, rsp.sp_out);
                    check_field("status_out", want.status_out, rsp.status_out);
                    check_field("mem_value", want.mem_value, rsp.mem_value);
                    check_field("write_back", {7'd0, want.write_back}, {7'd0, rsp.write_back});
                    check_field("branch_taken", {7'd0, want.branch_taken},
                                {7'd0, rsp.branch_taken});
                end
            end
            if (req_valid && req_ready)
            begin
                req_taken = 1'b1;
                expected_results.push_back(execute_instr(req));
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("cpu8_register_alu_execute_unit_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned real_instrs;
        logic [5:0] cmd;
        logic [7:0] operand;
        logic [7:0] edge_values [5];
        edge_values = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};

        // Directed: carries, overflow, compares, bit test, shifts, wraps
        queue_instr(cpu8_pkg::OP_LDA, 8'h7F, 1'b0);
        queue_instr(cpu8_pkg::OP_ADC, 8'h01, 1'b0);
        queue_instr(cpu8_pkg::OP_BVS, 8'h00, 1'b1);
        queue_instr(cpu8_pkg::OP_ADC, 8'hFF, 1'b0);
        queue_instr(cpu8_pkg::OP_BCS, 8'hFF, 1'b0);
        queue_instr(cpu8_pkg::OP_SEC, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_SBC, 8'h80, 1'b0);
        queue_instr(cpu8_pkg::OP_CMP, 8'hFF, 1'b0);
        queue_instr(cpu8_pkg::OP_LDX, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_CPX, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_BEQ, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_LDY, 8'hFF, 1'b0);
        queue_instr(cpu8_pkg::OP_CPY, 8'h01, 1'b0);
        queue_instr(cpu8_pkg::OP_BIT, 8'hC0, 1'b0);
        queue_instr(cpu8_pkg::OP_ASL, 8'h00, 1'b1);
        queue_instr(cpu8_pkg::OP_ROR, 8'h01, 1'b0);
        queue_instr(cpu8_pkg::OP_ROL, 8'h80, 1'b0);
        queue_instr(cpu8_pkg::OP_LSR, 8'hFF, 1'b1);
        queue_instr(cpu8_pkg::OP_INC, 8'hFF, 1'b0);
        queue_instr(cpu8_pkg::OP_DEC, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_DEX, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_TXS, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_TSX, 8'h00, 1'b0);
        queue_instr(cpu8_pkg::OP_STA, 8'hFF, 1'b1);
        queue_instr(CMD_UNUSED_TOP, 8'hFF, 1'b1);

        // Random: all operations, edge operands now and then, rare unused codes
        real_instrs = 0;
        while (real_instrs < RANDOM_INSTRS)
        begin
            if ($urandom_range(0, 15) == 0)
                cmd = 6'($urandom_range(int'(cpu8_pkg::OP_BEQ) + 1, int'(CMD_UNUSED_TOP)));
            else
                cmd = 6'($urandom_range(int'(cpu8_pkg::OP_ADC), int'(cpu8_pkg::OP_BEQ)));
            if ($urandom_range(0, 5) == 0)
                operand = edge_values[3'($urandom_range(0, 4))];
            else
                operand = 8'($urandom_range(0, 255));
            queue_instr(cmd, operand, 1'($urandom_range(0, 1)));
            if (cmd <= cpu8_pkg::OP_BEQ)
                real_instrs++;
        end

        // Hold reset, then release it away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: everything sent, every result back, then settle
        while (pending_instrs.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("cpu8_register_alu_execute_unit_tb passed");
        else
            $display("cpu8_register_alu_execute_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/cpu8_pkg.sv
design/cpu8_register_alu_execute_unit.sv
bench/cpu8_register_alu_execute_unit_tb.sv
